// ----- rtl/bounded_deque_with_search_defines.svh -----
// Assertion macros shared by the bounded deque RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// same-cycle implication
`define BDQS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bdqs_pkg.sv -----
// Shared types and constants for the bounded deque with search.
// No dependencies; used by the interfaces and every module of the block.
package bdqs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_PREPEND   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    RD_SEARCH,
    RD_HEAD,
    RD_TAIL
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    apply;
    logic    search;
    logic    cap_head;
    logic    load_out;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_search;
    logic search_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/bdqs_ifs.sv -----
// Valid/ready channel interfaces for the deque's request and response sides.
// Depends on bdqs_pkg for field widths.
interface bdqs_in_if;
  logic                                valid;
  logic                                ready;
  logic [bdqs_pkg::ACTION_W-1:0]       action;
  logic signed [bdqs_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface bdqs_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [bdqs_pkg::STATUS_W-1:0]       status;
  logic                                head_valid;
  logic signed [bdqs_pkg::VALUE_W-1:0] head_value;
  logic                                tail_valid;
  logic signed [bdqs_pkg::VALUE_W-1:0] tail_value;
  logic [bdqs_pkg::OCC_W-1:0]          occupancy;

  modport source (output valid, found, status, head_valid, head_value, tail_valid,
                  tail_value, occupancy, input ready);
  modport sink   (input valid, found, status, head_valid, head_value, tail_valid,
                  tail_value, occupancy, output ready);
endinterface

// ----- rtl/bdqs_dp.sv -----
// Datapath of the deque: ring memory, front index, count, search scan and
// the response register. Depends on bdqs_pkg, bdqs_out_if and the defines header.
`include "bounded_deque_with_search_defines.svh"

module bdqs_dp #(
  parameter int DEPTH      = bdqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bdqs_pkg::dp_cmd_t                   cmd,
  output bdqs_pkg::dp_stat_t                  stat,
  input  logic [bdqs_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [bdqs_pkg::VALUE_W-1:0] in_value,
  bdqs_out_if.source                          rsp
);
  import bdqs_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [IW:0]   DEPTH_X    = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [ACTION_W-1:0]   act;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] head_q;
  logic [CW-1:0]         idx;
  logic                  rd_pend;
  logic                  found;
  logic [STATUS_W-1:0]   status, status_next;
  logic                  out_valid;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr, rd_addr, tail_off;
  logic                  full, empty, match, issue;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] f, input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, f} + {1'b0, off};
    if (sum >= DEPTH_X) sum = sum - DEPTH_X;
    return sum[IW-1:0];
  endfunction

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign match    = rd_pend && (rd_data == key);
  assign issue    = cmd.search && (idx < count) && !match;
  assign tail_off = count[IW-1:0] - IW'(1);

  assign stat.is_search  = (act == ACT_SEARCH);
  assign stat.search_end = match || (idx == count);
  assign stat.out_free   = !out_valid || rsp.ready;

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = slot(front, count[IW-1:0]);
    case (act)
      ACT_PREPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_next = (front == '0) ? LAST_SLOT : front - IW'(1);
          wr_addr    = front_next;
          wr_en      = cmd.apply;
          count_next = count + CW'(1);
        end
      end
      ACT_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_en      = cmd.apply;
          count_next = count + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          front_next = (front == LAST_SLOT) ? '0 : front + IW'(1);
          count_next = count - CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_SEARCH: rd_addr = slot(front, idx[IW-1:0]);
      RD_HEAD:   rd_addr = front;
      RD_TAIL:   rd_addr = empty ? front : slot(front, tail_off);
      default:   rd_addr = front;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.apply) begin
        front <= front_next;
        count <= count_next;
      end
      rd_pend <= issue;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= in_action;
      key <= DATA_WIDTH'(in_value);
    end
    if (cmd.apply) begin
      status <= status_next;
      found  <= 1'b0;
      idx    <= '0;
    end else if (cmd.search) begin
      if (match) found <= 1'b1;
      if (issue) idx <= idx + CW'(1);
    end
    if (cmd.cap_head) begin
      head_q <= rd_data;
    end
    if (cmd.load_out) begin
      rsp.found      <= found && (act == ACT_SEARCH);
      rsp.status     <= status;
      rsp.head_valid <= !empty;
      rsp.tail_valid <= !empty;
      rsp.head_value <= empty ? '0 : VALUE_W'(head_q);
      rsp.tail_value <= empty ? '0 : VALUE_W'(rd_data);
      rsp.occupancy  <= OCC_W'(count);
    end
  end

  assign rsp.valid = out_valid;

  `BDQS_ASSERT_NEXT(a_full_drop, clk, rst,
    cmd.apply && full && (act == ACT_PREPEND || act == ACT_APPEND),
    status == ST_FULL && $stable(count), "push on full queue changed the count")
  `BDQS_ASSERT_NEXT(a_pop_dec, clk, rst,
    cmd.apply && !empty && (act == ACT_POP_FRONT || act == ACT_POP_BACK),
    count == $past(count) - CW'(1), "pop did not decrement the count")
  `BDQS_ASSERT_NEXT(a_match_found, clk, rst, cmd.search && match, found,
    "search match not recorded")
  `BDQS_ASSERT_NOW(a_load_free, clk, rst, cmd.load_out, !out_valid || rsp.ready,
    "response overwritten while still pending")

endmodule

// ----- rtl/bdqs_ctrl.sv -----
// Sequencer of the deque: accept, apply, search scan, head/tail read, respond.
// Depends on bdqs_pkg for the command and status structs.
module bdqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdqs_pkg::dp_stat_t stat,
  output bdqs_pkg::dp_cmd_t  cmd
);
  import bdqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SEARCH,
    S_HEAD,
    S_TAIL,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '{capture: 1'b0, apply: 1'b0, search: 1'b0, cap_head: 1'b0,
                   load_out: 1'b0, rd_sel: RD_HEAD};
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = stat.is_search ? S_SEARCH : S_HEAD;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        cmd.rd_sel = RD_SEARCH;
        if (stat.search_end) state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.rd_sel = RD_HEAD;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        cmd.rd_sel   = RD_TAIL;
        cmd.cap_head = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        cmd.rd_sel = RD_TAIL;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/bounded_deque_with_search.sv -----
// Top level of the bounded double-ended queue with key search.
// Depends on bdqs_pkg, bdqs_ifs, bdqs_ctrl and bdqs_dp.
//
// Usage:
//   req carries one transaction per action: action (0 prepend, 1 append,
//   2 pop front, 3 pop back, 4 search) and a signed 32-bit value.
//   rsp returns exactly one transaction per request: found, status
//   (0 done, 1 push dropped as full, 2 pop on empty ignored), head and
//   tail values with their valid flags, and the occupancy.
//   Entries live in a ring memory of DEPTH words with one read port.
//   Pushes, pops and idle codes pass through the apply, head-read, tail-read
//   and finish states from acceptance to rsp.valid; a search adds a scan of
//   the entries up to the first match (at most the occupancy), one memory
//   read per cycle. req.ready returns in the cycle after the response is
//   loaded, so only one request is processed at a time.
//   Reset (rst, synchronous) empties the queue and drops any pending
//   response; memory contents are not cleared.
//   If rsp is stalled, the response is held in its register; one further
//   request may be taken and processed up to its response, which then
//   waits until the held transaction is taken.
module bounded_deque_with_search #(
  parameter int DEPTH      = bdqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdqs_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bdqs_in_if.sink    req,
  bdqs_out_if.source rsp
);
  import bdqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdqs_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (req.action),
    .in_value  (req.value),
    .rsp       (rsp)
  );

endmodule

// ----- tb/bounded_deque_with_search_tb.sv -----
// Self-checking testbench for bounded_deque_with_search: a ring model of the deque predicts
// every response, compared field by field under random idling and back-pressure.
// Depends on bdqs_pkg, the bdqs_in_if/bdqs_out_if interfaces and the block's RTL.
module bounded_deque_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdqs_pkg::*;

  localparam int Q_DEPTH = DEPTH_DEF;

  localparam logic [ACTION_W-1:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_HI  = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      found;
    logic [STATUS_W-1:0]       status;
    logic                      head_valid;
    logic signed [VALUE_W-1:0] head_value;
    logic                      tail_valid;
    logic signed [VALUE_W-1:0] tail_value;
    logic [OCC_W-1:0]          occupancy;
  } deque_rsp_t;

  logic clk;
  logic rst;

  bdqs_in_if  req_if ();
  bdqs_out_if rsp_if ();

  bounded_deque_with_search uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic signed [VALUE_W-1:0] ring_model [Q_DEPTH];
  int                        front_model = 0;
  int                        count_model = 0;
  deque_rsp_t                expected_rsp [$];
  logic signed [VALUE_W-1:0] value_pool [8];

  int errors      = 0;
  int items_sent  = 0;
  int rsp_seen    = 0;
  int search_hits = 0;
  int push_drops  = 0;
  int empty_pops  = 0;
  int hold_off    = 0;
  bit no_idle     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d responses outstanding", expected_rsp.size());
    $display("bounded_deque_with_search regression: fail");
    $finish;
  end

  function automatic deque_rsp_t deque_step(input logic [ACTION_W-1:0] act,
                                            input logic signed [VALUE_W-1:0] val);
    deque_rsp_t r;
    r = '0;
    case (act)
      ACT_PREPEND: begin
        if (count_model >= Q_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front_model = (front_model + Q_DEPTH - 1) % Q_DEPTH;
          ring_model[front_model] = val;
          count_model++;
        end
      end
      ACT_APPEND: begin
        if (count_model >= Q_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_model[(front_model + count_model) % Q_DEPTH] = val;
          count_model++;
        end
      end
      ACT_POP_FRONT: begin
        if (count_model == 0) begin
          r.status = ST_EMPTY;
        end else begin
          front_model = (front_model + 1) % Q_DEPTH;
          count_model--;
        end
      end
      ACT_POP_BACK: begin
        if (count_model == 0) r.status = ST_EMPTY;
        else count_model--;
      end
      ACT_SEARCH: begin
        for (int i = 0; i < count_model; i++)
          if (ring_model[(front_model + i) % Q_DEPTH] == val) r.found = 1'b1;
      end
      default: ;
    endcase
    if (count_model != 0) begin
      r.head_valid = 1'b1;
      r.tail_valid = 1'b1;
      r.head_value = ring_model[front_model];
      r.tail_value = ring_model[(front_model + count_model - 1) % Q_DEPTH];
    end
    r.occupancy = count_model[OCC_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return value_pool[$urandom_range(0, 7)];
    if (r < 60 && count_model > 0)
      return ring_model[(front_model + $urandom_range(0, count_model - 1)) % Q_DEPTH];
    return $urandom;
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    if (r < 3 + push_pct) return $urandom_range(0, 1) ? ACT_APPEND : ACT_PREPEND;
    if (r < 3 + push_pct + pop_pct) return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    return ACT_SEARCH;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("response %0d %s: got %0h, want %0h", rsp_seen, name, got, want));
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic signed [VALUE_W-1:0] val);
    int gap;
    @(negedge clk);
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= val;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    expected_rsp.push_back(deque_step(act, val));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // empty-queue pops and searches, extremes of value, reserved codes
  task automatic test_directed();
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, -32'sd1);
    send_item(ACT_SEARCH, 32'sd0);
    send_item(ACT_RSVD_LO, VAL_MAX);
    send_item(ACT_PREPEND, VAL_MAX);
    send_item(ACT_APPEND, VAL_MIN);
    send_item(ACT_SEARCH, VAL_MAX);
    send_item(ACT_SEARCH, VAL_MIN);
    send_item(ACT_SEARCH, 32'sd0);
    send_item(ACT_RSVD_MID, VAL_MIN);
    send_item(ACT_PREPEND, -32'sd1);
    send_item(ACT_APPEND, 32'sd0);
    send_item(ACT_SEARCH, 32'sd0);
    send_item(ACT_SEARCH, -32'sd1);
    send_item(ACT_POP_BACK, VAL_MAX);
    send_item(ACT_POP_FRONT, VAL_MIN);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_RSVD_HI, -32'sd1);
    send_item(ACT_SEARCH, VAL_MIN);
    wait_all_results();
  endtask

  // fill to capacity from either end, push past full, then drain past empty
  task automatic test_fill_overflow(input int rounds);
    repeat (rounds) begin
      while (count_model < Q_DEPTH)
        send_item($urandom_range(0, 1) ? ACT_APPEND : ACT_PREPEND, pick_value());
      repeat ($urandom_range(2, 4))
        send_item($urandom_range(0, 1) ? ACT_APPEND : ACT_PREPEND, pick_value());
      repeat (3) send_item(ACT_SEARCH, pick_value());
      while (count_model > 0) begin
        if ($urandom_range(0, 3) == 0) send_item(ACT_SEARCH, pick_value());
        else send_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
      end
      repeat ($urandom_range(1, 3))
        send_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
      send_item(ACT_SEARCH, pick_value());
    end
    wait_all_results();
  endtask

  // response side held off while requests keep coming
  task automatic test_backpressure();
    hold_off = 300;
    repeat (40) send_item(pick_action(45, 25), pick_value());
    wait_all_results();
  endtask

  task automatic test_back_to_back(input int n);
    no_idle = 1'b1;
    repeat (n) send_item(pick_action(35, 35), pick_value());
    wait_all_results();
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix(input int phases);
    int kind;
    repeat (phases) begin
      kind = $urandom_range(0, 2);
      repeat (50) begin
        case (kind)
          0:       send_item(pick_action(60, 20), pick_value());
          1:       send_item(pick_action(20, 60), pick_value());
          default: send_item(pick_action(35, 35), pick_value());
        endcase
      end
    end
    wait_all_results();
  endtask

  initial begin : rsp_driver
    int idle_left;
    idle_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        rsp_if.ready <= 1'b0;
        hold_off--;
      end else if (idle_left > 0) begin
        rsp_if.ready <= 1'b0;
        idle_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        idle_left = pick_gap();
      end
    end
  end

  initial begin : rsp_checker
    deque_rsp_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          report_error($sformatf("response %0d with no request outstanding", rsp_seen));
        end else begin
          want = expected_rsp.pop_front();
          check_field("found", rsp_if.found, want.found);
          check_field("status", rsp_if.status, want.status);
          check_field("head_valid", rsp_if.head_valid, want.head_valid);
          check_field("head_value", rsp_if.head_value, want.head_value);
          check_field("tail_valid", rsp_if.tail_valid, want.tail_valid);
          check_field("tail_value", rsp_if.tail_value, want.tail_value);
          check_field("occupancy", rsp_if.occupancy, want.occupancy);
          if (want.found) search_hits++;
          if (want.status == ST_FULL) push_drops++;
          if (want.status == ST_EMPTY) empty_pops++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_if.valid  = 1'b0;
    req_if.action = ACT_PREPEND;
    req_if.value  = '0;
    value_pool[0] = 32'sd0;
    value_pool[1] = -32'sd1;
    value_pool[2] = VAL_MAX;
    value_pool[3] = VAL_MIN;
    value_pool[4] = 32'sd1;
    for (int i = 5; i < 8; i++) value_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_overflow(6);
    test_backpressure();
    test_back_to_back(250);
    test_random_mix(20);

    if (expected_rsp.size() != 0)
      report_error($sformatf("%0d responses never arrived", expected_rsp.size()));
    $display("%0d requests, %0d responses: %0d search hits, %0d full drops, %0d empty pops",
             items_sent, rsp_seen, search_hits, push_drops, empty_pops);
    $display("covered fill/drain past both limits, stalled output and back-to-back traffic");
    if (errors == 0) begin
      $display("bounded_deque_with_search regression: pass");
    end else begin
      $display("bounded_deque_with_search regression: fail");
    end
    $finish;
  end

endmodule
